// File: rtl/ipv4fwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4fwd_pkg
// Shared types and codes of the IPv4 forwarding decision block.
// ----------------------------------------------------------------------------
package ipv4fwd_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_CLASSIFY = 2'd1,
        CMD_LOOKUP   = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ACT_NONE          = 4'd0,
        ACT_NET_UNREACH   = 4'd1,
        ACT_ECHO_REPLY    = 4'd2,
        ACT_PORT_UNREACH  = 4'd3,
        ACT_TIME_EXCEEDED = 4'd4,
        ACT_FORWARD       = 4'd5,
        ACT_WRITTEN       = 4'd6,
        ACT_HIT           = 4'd7,
        ACT_MISS          = 4'd8
    } action_t;

    typedef enum logic [2:0] {
        REG_PORT_IP_0    = 3'd0,
        REG_PORT_IP_1    = 3'd1,
        REG_PORT_IP_2    = 3'd2,
        REG_PORT_IP_3    = 3'd3,
        REG_PORTS_IN_USE = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    localparam logic [7:0] PROTO_ICMP         = 8'd1;
    localparam logic [7:0] ICMP_ECHO_REQUEST  = 8'd8;
    localparam logic [7:0] ICMP_UNREACH       = 8'd3;
    localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] CODE_NET           = 8'd0;
    localparam logic [7:0] CODE_PORT          = 8'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  entry_slot;
        logic [31:0] address;
        logic [31:0] entry_mask;
        logic [31:0] entry_gateway;
        logic [1:0]  entry_port;
        logic        entry_valid;
        logic [7:0]  protocol;
        logic [7:0]  ttl;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
    } req_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  reply_type;
        logic [7:0]  reply_code;
        logic [1:0]  out_port;
        logic [31:0] next_hop;
        logic [7:0]  new_ttl;
        logic        route_found;
    } rsp_t;

    typedef struct packed {
        logic [3:0][31:0] port_ip;
        logic [2:0]       ports_in_use;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic req_scan;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/ipv4fwd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4fwd_req_if
// Request channel: valid/ready handshake with a request payload.
// ----------------------------------------------------------------------------
interface ipv4fwd_req_if;
    import ipv4fwd_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ipv4fwd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4fwd_rsp_if
// Result channel: valid/ready handshake with a result payload.
// ----------------------------------------------------------------------------
interface ipv4fwd_rsp_if;
    import ipv4fwd_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ipv4fwd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4fwd_cfg
// APB register file holding the router port addresses and port count.
// ----------------------------------------------------------------------------
module ipv4fwd_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ipv4fwd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ipv4fwd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [ipv4fwd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                    pready,
    output ipv4fwd_pkg::cfg_t                       cfg
);
    import ipv4fwd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    reg_index_t index;

    assign index  = reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_PORT_IP_0:    cfg_next.port_ip[0] = pwdata;
                REG_PORT_IP_1:    cfg_next.port_ip[1] = pwdata;
                REG_PORT_IP_2:    cfg_next.port_ip[2] = pwdata;
                REG_PORT_IP_3:    cfg_next.port_ip[3] = pwdata;
                REG_PORTS_IN_USE: cfg_next.ports_in_use = pwdata[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_PORT_IP_0:    prdata = cfg_reg.port_ip[0];
            REG_PORT_IP_1:    prdata = cfg_reg.port_ip[1];
            REG_PORT_IP_2:    prdata = cfg_reg.port_ip[2];
            REG_PORT_IP_3:    prdata = cfg_reg.port_ip[3];
            REG_PORTS_IN_USE: prdata = {29'd0, cfg_reg.ports_in_use};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ipv4fwd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4fwd_ctrl
// Sequencer: accept a request, scan the route table, hand off the result.
// ----------------------------------------------------------------------------
module ipv4fwd_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire ipv4fwd_pkg::dp_status_t status,
    output ipv4fwd_pkg::dp_cmd_t         cmd
);
    import ipv4fwd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.req_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/ipv4fwd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4fwd_dp
// Route table memories, prefix scan, packet classification, result register.
// ----------------------------------------------------------------------------
module ipv4fwd_dp #(
    parameter int ROUTE_SLOTS = 16,
    parameter int PORT_COUNT  = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ipv4fwd_pkg::req_t        req_data,
    input  wire ipv4fwd_pkg::cfg_t        cfg,
    input  wire ipv4fwd_pkg::dp_cmd_t     cmd,
    output ipv4fwd_pkg::dp_status_t       status,
    output logic                          rsp_valid,
    input  wire logic                    rsp_ready,
    output ipv4fwd_pkg::rsp_t             rsp_data
);
    import ipv4fwd_pkg::*;

    localparam int SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;

    logic [31:0] dest_mem [ROUTE_SLOTS];
    logic [31:0] mask_mem [ROUTE_SLOTS];
    logic [31:0] gw_mem   [ROUTE_SLOTS];
    logic [1:0]  port_mem [ROUTE_SLOTS];
    logic        valid_reg [ROUTE_SLOTS];

    req_t              req_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              rd_vld_reg;
    logic              vbit_rd_reg;
    logic [31:0]       dest_rd_reg;
    logic [31:0]       mask_rd_reg;
    logic [31:0]       gw_rd_reg;
    logic [1:0]        port_rd_reg;
    logic              found_reg;
    logic [31:0]       best_mask_reg;
    logic [31:0]       best_gw_reg;
    logic [1:0]        best_port_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    logic [8:0]        slot_ext;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;
    logic              hit;
    logic              take;
    logic [2:0]        ports_eff;
    logic              is_local;
    rsp_t              res;

    assign slot_ext = {5'd0, req_data.entry_slot};
    assign wr_idx   = slot_ext[SLOT_W-1:0];
    assign wr_en    = cmd.accept && (req_data.cmd == CMD_WRITE)
                      && (slot_ext < 9'(ROUTE_SLOTS));

    assign status.req_scan  = (req_data.cmd == CMD_CLASSIFY)
                              || (req_data.cmd == CMD_LOOKUP);
    assign status.scan_last = (idx_reg == SLOT_W'(ROUTE_SLOTS - 1));
    assign status.out_free  = !out_valid_reg || rsp_ready;

    assign hit  = rd_vld_reg && vbit_rd_reg
                  && (((dest_rd_reg ^ req_reg.address) & mask_rd_reg) == 32'd0);
    assign take = hit && (!found_reg || (best_mask_reg < mask_rd_reg));

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dest_mem[wr_idx] <= req_data.address;
            mask_mem[wr_idx] <= req_data.entry_mask;
            gw_mem[wr_idx]   <= req_data.entry_gateway;
            port_mem[wr_idx] <= req_data.entry_port;
        end
        dest_rd_reg <= dest_mem[idx_reg];
        mask_rd_reg <= mask_mem[idx_reg];
        gw_rd_reg   <= gw_mem[idx_reg];
        port_rd_reg <= port_mem[idx_reg];
        vbit_rd_reg <= valid_reg[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg       <= req_data;
            best_mask_reg <= '0;
            best_gw_reg   <= '0;
            best_port_reg <= '0;
        end
        else if (take)
        begin
            best_mask_reg <= mask_rd_reg;
            best_gw_reg   <= gw_rd_reg;
            best_port_reg <= port_rd_reg;
        end
        if (cmd.finish)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROUTE_SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= req_data.entry_valid;
            end
            rd_vld_reg <= cmd.issue;
            if (cmd.accept)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue && !status.scan_last)
                begin
                    idx_reg <= idx_reg + SLOT_W'(1);
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        ports_eff = (cfg.ports_in_use > 3'(PORT_COUNT)) ? 3'(PORT_COUNT)
                                                        : cfg.ports_in_use;
        is_local = 1'b0;
        for (int i = 0; i < PORT_COUNT; i++)
        begin
            if ((3'(i) < ports_eff) && (cfg.port_ip[i] == req_reg.address))
            begin
                is_local = 1'b1;
            end
        end
    end

    always_comb
    begin
        res = '0;
        unique case (req_reg.cmd)
            CMD_WRITE:
            begin
                res.action = ACT_WRITTEN;
            end
            CMD_LOOKUP:
            begin
                res.route_found = found_reg;
                res.out_port    = best_port_reg;
                res.next_hop    = best_gw_reg;
                res.action      = found_reg ? ACT_HIT : ACT_MISS;
            end
            CMD_CLASSIFY:
            begin
                res.route_found = found_reg;
                res.out_port    = best_port_reg;
                res.next_hop    = best_gw_reg;
                if (!is_local && !found_reg)
                begin
                    res.action     = ACT_NET_UNREACH;
                    res.reply_type = ICMP_UNREACH;
                    res.reply_code = CODE_NET;
                end
                else if (is_local)
                begin
                    if (req_reg.protocol == PROTO_ICMP)
                    begin
                        if ((req_reg.msg_type == ICMP_ECHO_REQUEST)
                            && (req_reg.msg_code == 8'd0))
                        begin
                            res.action = ACT_ECHO_REPLY;
                        end
                    end
                    else
                    begin
                        res.action     = ACT_PORT_UNREACH;
                        res.reply_type = ICMP_UNREACH;
                        res.reply_code = CODE_PORT;
                    end
                end
                else if (req_reg.ttl <= 8'd1)
                begin
                    res.action     = ACT_TIME_EXCEEDED;
                    res.reply_type = ICMP_TIME_EXCEEDED;
                end
                else
                begin
                    res.action  = ACT_FORWARD;
                    res.new_ttl = req_reg.ttl - 8'd1;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/ipv4_forward_decision_lpm_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_forward_decision_lpm_top
// IPv4 forwarding decision with a longest-prefix-match routing table.
// ----------------------------------------------------------------------------
// Route write or unused command: the request goes straight to the finish state,
//   which loads the result register; one request is in flight at a time.
// Classify or lookup: the request scans every route slot, then drains through
//   the read registers before finish loads the result; the single table read port
//   scans one slot per cycle, and an untaken result holds the next request.
// Reset clears the control registers and all route valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module ipv4_forward_decision_lpm_top #(
    parameter int ROUTE_SLOTS = 16,
    parameter int PORT_COUNT  = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    ipv4fwd_req_if.sink                             req,
    ipv4fwd_rsp_if.source                           rsp,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ipv4fwd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ipv4fwd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [ipv4fwd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                    pready
);
    import ipv4fwd_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       req_ready;
    logic       rsp_valid;
    rsp_t       rsp_data;

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

    ipv4fwd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipv4fwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    ipv4fwd_dp #(
        .ROUTE_SLOTS (ROUTE_SLOTS),
        .PORT_COUNT  (PORT_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .cfg       (cfg),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_data)
    );

    a_one_request_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req_ready) |=> !req_ready
    ) else $error("request accepted while another is in flight");

    a_finish_needs_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        dp_cmd.finish |-> (!rsp_valid || rsp.ready)
    ) else $error("result loaded over an untaken result");

    a_result_from_finish: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(dp_cmd.finish)
    ) else $error("result appeared without a finish");

endmodule
`default_nettype wire
